>>> rtl/hiw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hiw_pkg
// Shared widths, reset values, codes and channel payload types for the heat
// index and warning core.
// ----------------------------------------------------------------------------
package hiw_pkg;

	localparam int COEF_FRAC_BITS_DEF = 32;

	localparam int TEMP_W    = 16;
	localparam int HUM_W     = 15;
	localparam int HI_W      = 24;
	localparam int WARN_W    = 2;
	localparam int CAT_W     = 3;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;

	// low part width when a monomial is split for the coefficient multiply
	localparam int SPLIT_W = 16;

	localparam logic signed [CFG_W-1:0] FORMULA_RST = 16'sd6912;
	localparam logic signed [CFG_W-1:0] CAUTION_RST = 16'sd7680;
	localparam logic signed [CFG_W-1:0] EXTREME_RST = 16'sd8960;
	localparam logic signed [CFG_W-1:0] DANGER_RST  = 16'sd10240;

	localparam logic signed [TEMP_W-1:0] COLD_MIN = 16'sd2560;
	localparam logic signed [TEMP_W-1:0] COOL_MIN = 16'sd5120;
	localparam logic signed [TEMP_W-1:0] WARM_MIN = 16'sd7680;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FORMULA = 2'd0,
		REG_CAUTION = 2'd1,
		REG_EXTREME = 2'd2,
		REG_DANGER  = 2'd3
	} cfg_reg_t;

	typedef enum logic [WARN_W-1:0] {
		WARN_NONE    = 2'd0,
		WARN_CAUTION = 2'd1,
		WARN_EXTREME = 2'd2,
		WARN_DANGER  = 2'd3
	} warn_t;

	typedef enum logic [CAT_W-1:0] {
		CAT_FREEZING = 3'd0,
		CAT_COLD     = 3'd1,
		CAT_COOL     = 3'd2,
		CAT_WARM     = 3'd3,
		CAT_HOT      = 3'd4
	} cat_t;

	typedef struct packed {
		logic signed [TEMP_W-1:0] air_temp;
		logic [HUM_W-1:0]         rel_humidity;
	} reading_t;

	typedef struct packed {
		logic signed [HI_W-1:0] heat_index;
		logic [WARN_W-1:0]      warning_level;
		logic [CAT_W-1:0]       temp_category;
	} report_t;

endpackage

>>> rtl/hiw_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hiw_stream_if
// Valid/ready stream channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
interface hiw_stream_if #(
	parameter type payload_t = logic
);

	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);

endinterface

>>> rtl/heat_index_warning_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heat_index_warning_core
// Heat index polynomial, warning level and temperature category per reading.
// ----------------------------------------------------------------------------
// Usage:
//   reading : valid/ready sink, one transfer per sample (air_temp, rel_humidity)
//   report  : valid/ready source, one transfer per sample (heat_index,
//             warning_level, temp_category), in input order
//   cfg_*   : register write port (formula threshold, caution, extreme and
//             danger levels); write only while no sample is in flight
// A reading passes seven pipeline stages (three products of the inputs, three
// monomials, split coefficient products, term alignment, two adder levels,
// floor and saturate) and then an output register before its report is valid.
// Throughput is one reading per cycle while report is not stalled.
// Each stage holds its own valid bit; when report is stalled the pipe keeps
// accepting until every stage is full, then reading.ready drops. Nothing is
// dropped or repeated.
// Reset empties the pipe and loads the default levels (27, 30, 35, 40 C).
// ----------------------------------------------------------------------------
module heat_index_warning_core #(
	parameter int COEF_FRAC_BITS = hiw_pkg::COEF_FRAC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [hiw_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [hiw_pkg::CFG_W-1:0]      cfg_data,
	hiw_stream_if.sink                     reading,
	hiw_stream_if.source                   report
);

	localparam int W      = COEF_FRAC_BITS;
	localparam int TW     = hiw_pkg::TEMP_W;
	localparam int SW     = hiw_pkg::SPLIT_W;
	localparam int HW     = hiw_pkg::HI_W;
	localparam int P2_W   = 2 * TW;
	localparam int P3_W   = 3 * TW;
	localparam int P4_W   = 4 * TW;
	localparam int ACC_W  = W + 56;
	localparam int FLR_SH = W + 24;
	localparam int Y_W    = ACC_W - FLR_SH;

	// coefficient widths, signed, from the magnitude bound of each term
	localparam int K2_W = W + 2;
	localparam int K3_W = W + 3;
	localparam int K4_W = W - 1;
	localparam int K5_W = W - 5;
	localparam int K6_W = W - 4;
	localparam int K7_W = W - 7;
	localparam int K8_W = W - 9;
	localparam int K9_W = W - 17;

	// coefficient magnitudes rounded half away from zero
	localparam logic [127:0] M1 =
		(((128'd878469475556 << (W + 1)) / 128'd100000000000) + 128'd1) >> 1;
	localparam logic [127:0] M2 =
		(((128'd161139411 << (W + 1)) / 128'd100000000) + 128'd1) >> 1;
	localparam logic [127:0] M3 =
		(((128'd233854883889 << (W + 1)) / 128'd100000000000) + 128'd1) >> 1;
	localparam logic [127:0] M4 =
		(((128'd14611605 << (W + 1)) / 128'd100000000) + 128'd1) >> 1;
	localparam logic [127:0] M5 =
		(((128'd12308094 << (W + 1)) / 128'd1000000000) + 128'd1) >> 1;
	localparam logic [127:0] M6 =
		(((128'd164248277778 << (W + 1)) / 128'd10000000000000) + 128'd1) >> 1;
	localparam logic [127:0] M7 =
		(((128'd2211732 << (W + 1)) / 128'd1000000000) + 128'd1) >> 1;
	localparam logic [127:0] M8 =
		(((128'd72546 << (W + 1)) / 128'd100000000) + 128'd1) >> 1;
	localparam logic [127:0] M9 =
		(((128'd3582 << (W + 1)) / 128'd1000000000) + 128'd1) >> 1;

	localparam logic signed [ACC_W-1:0] T1 = ACC_W'(128'd0 - (M1 << 32));
	localparam logic signed [K2_W-1:0]  K2 = K2_W'(M2);
	localparam logic signed [K3_W-1:0]  K3 = K3_W'(M3);
	localparam logic signed [K4_W-1:0]  K4 = K4_W'(128'd0 - M4);
	localparam logic signed [K5_W-1:0]  K5 = K5_W'(128'd0 - M5);
	localparam logic signed [K6_W-1:0]  K6 = K6_W'(128'd0 - M6);
	localparam logic signed [K7_W-1:0]  K7 = K7_W'(M7);
	localparam logic signed [K8_W-1:0]  K8 = K8_W'(M8);
	localparam logic signed [K9_W-1:0]  K9 = K9_W'(128'd0 - M9);

	localparam logic signed [Y_W-1:0] Y_MAX = Y_W'(32'sh007FFFFF);
	localparam logic signed [Y_W-1:0] Y_MIN = Y_W'(-32'sh00800000);
	localparam logic signed [HW-1:0]  HI_MAX = 24'sh7FFFFF;
	localparam logic signed [HW-1:0]  HI_MIN = 24'sh800000;

	// configuration registers
	logic signed [hiw_pkg::CFG_W-1:0] formula_q, caution_q, extreme_q, danger_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			formula_q <= hiw_pkg::FORMULA_RST;
			caution_q <= hiw_pkg::CAUTION_RST;
			extreme_q <= hiw_pkg::EXTREME_RST;
			danger_q  <= hiw_pkg::DANGER_RST;
		end else if (cfg_we) begin
			unique case (hiw_pkg::cfg_reg_t'(cfg_index))
				hiw_pkg::REG_FORMULA: formula_q <= $signed(cfg_data);
				hiw_pkg::REG_CAUTION: caution_q <= $signed(cfg_data);
				hiw_pkg::REG_EXTREME: extreme_q <= $signed(cfg_data);
				hiw_pkg::REG_DANGER:  danger_q  <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	// flow control
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, out_vld_q;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5, rdy_s6, rdy_s7, rdy_o;

	assign rdy_o  = !out_vld_q || report.ready;
	assign rdy_s7 = !vld_s7 || rdy_o;
	assign rdy_s6 = !vld_s6 || rdy_s7;
	assign rdy_s5 = !vld_s5 || rdy_s6;
	assign rdy_s4 = !vld_s4 || rdy_s5;
	assign rdy_s3 = !vld_s3 || rdy_s4;
	assign rdy_s2 = !vld_s2 || rdy_s3;
	assign rdy_s1 = !vld_s1 || rdy_s2;

	assign reading.ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			vld_s4    <= 1'b0;
			vld_s5    <= 1'b0;
			vld_s6    <= 1'b0;
			vld_s7    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (rdy_s1) vld_s1 <= reading.valid;
			if (rdy_s2) vld_s2 <= vld_s1;
			if (rdy_s3) vld_s3 <= vld_s2;
			if (rdy_s4) vld_s4 <= vld_s3;
			if (rdy_s5) vld_s5 <= vld_s4;
			if (rdy_s6) vld_s6 <= vld_s5;
			if (rdy_s7) vld_s7 <= vld_s6;
			if (rdy_o)  out_vld_q <= vld_s7;
		end
	end

	// stage 1: input products, bypass decision and category
	logic signed [TW-1:0] t_in, r_in;
	hiw_pkg::cat_t        cat_in;

	assign t_in = reading.payload.air_temp;
	assign r_in = $signed({1'b0, reading.payload.rel_humidity});

	always_comb begin
		if (t_in < 16'sd0)                 cat_in = hiw_pkg::CAT_FREEZING;
		else if (t_in < hiw_pkg::COLD_MIN) cat_in = hiw_pkg::CAT_COLD;
		else if (t_in < hiw_pkg::COOL_MIN) cat_in = hiw_pkg::CAT_COOL;
		else if (t_in < hiw_pkg::WARM_MIN) cat_in = hiw_pkg::CAT_WARM;
		else                               cat_in = hiw_pkg::CAT_HOT;
	end

	logic signed [TW-1:0]   t_s1, r_s1;
	logic signed [P2_W-1:0] tt_s1, rr_s1, tr_s1;
	logic                   byp_s1;
	hiw_pkg::cat_t          cat_s1;

	always_ff @(posedge clk) begin
		if (rdy_s1 && reading.valid) begin
			t_s1   <= t_in;
			r_s1   <= r_in;
			tt_s1  <= t_in * t_in;
			rr_s1  <= r_in * r_in;
			tr_s1  <= t_in * r_in;
			byp_s1 <= t_in < formula_q;
			cat_s1 <= cat_in;
		end
	end

	// stage 2: third and fourth order monomials
	logic signed [TW-1:0]   t_s2, r_s2;
	logic signed [P2_W-1:0] tt_s2, rr_s2, tr_s2;
	logic signed [P3_W-1:0] ttr_s2, trr_s2;
	logic signed [P4_W-1:0] ttrr_s2;
	logic                   byp_s2;
	hiw_pkg::cat_t          cat_s2;

	always_ff @(posedge clk) begin
		if (rdy_s2 && vld_s1) begin
			t_s2    <= t_s1;
			r_s2    <= r_s1;
			tt_s2   <= tt_s1;
			rr_s2   <= rr_s1;
			tr_s2   <= tr_s1;
			ttr_s2  <= tt_s1 * r_s1;
			trr_s2  <= t_s1 * rr_s1;
			ttrr_s2 <= tt_s1 * rr_s1;
			byp_s2  <= byp_s1;
			cat_s2  <= cat_s1;
		end
	end

	// stage 3: coefficient products on t, r and the split monomials
	logic signed [SW:0]        tr_lo, tt_lo, rr_lo, ttr_lo, trr_lo, ttrr_lo;
	logic signed [P2_W-SW-1:0] tr_hi, tt_hi, rr_hi;
	logic signed [P3_W-SW-1:0] ttr_hi, trr_hi;
	logic signed [P4_W-SW-1:0] ttrr_hi;

	assign tr_lo   = $signed({1'b0, tr_s2[SW-1:0]});
	assign tt_lo   = $signed({1'b0, tt_s2[SW-1:0]});
	assign rr_lo   = $signed({1'b0, rr_s2[SW-1:0]});
	assign ttr_lo  = $signed({1'b0, ttr_s2[SW-1:0]});
	assign trr_lo  = $signed({1'b0, trr_s2[SW-1:0]});
	assign ttrr_lo = $signed({1'b0, ttrr_s2[SW-1:0]});
	assign tr_hi   = $signed(tr_s2[P2_W-1:SW]);
	assign tt_hi   = $signed(tt_s2[P2_W-1:SW]);
	assign rr_hi   = $signed(rr_s2[P2_W-1:SW]);
	assign ttr_hi  = $signed(ttr_s2[P3_W-1:SW]);
	assign trr_hi  = $signed(trr_s2[P3_W-1:SW]);
	assign ttrr_hi = $signed(ttrr_s2[P4_W-1:SW]);

	logic signed [K2_W+TW-1:0]        p2_s3;
	logic signed [K3_W+TW-1:0]        p3_s3;
	logic signed [K4_W+SW:0]          p4l_s3;
	logic signed [K4_W+P2_W-SW-1:0]   p4h_s3;
	logic signed [K5_W+SW:0]          p5l_s3;
	logic signed [K5_W+P2_W-SW-1:0]   p5h_s3;
	logic signed [K6_W+SW:0]          p6l_s3;
	logic signed [K6_W+P2_W-SW-1:0]   p6h_s3;
	logic signed [K7_W+SW:0]          p7l_s3;
	logic signed [K7_W+P3_W-SW-1:0]   p7h_s3;
	logic signed [K8_W+SW:0]          p8l_s3;
	logic signed [K8_W+P3_W-SW-1:0]   p8h_s3;
	logic signed [K9_W+SW:0]          p9l_s3;
	logic signed [K9_W+P4_W-SW-1:0]   p9h_s3;
	logic signed [TW-1:0]             t_s3;
	logic                             byp_s3;
	hiw_pkg::cat_t                    cat_s3;

	always_ff @(posedge clk) begin
		if (rdy_s3 && vld_s2) begin
			p2_s3  <= K2 * t_s2;
			p3_s3  <= K3 * r_s2;
			p4l_s3 <= K4 * tr_lo;
			p4h_s3 <= K4 * tr_hi;
			p5l_s3 <= K5 * tt_lo;
			p5h_s3 <= K5 * tt_hi;
			p6l_s3 <= K6 * rr_lo;
			p6h_s3 <= K6 * rr_hi;
			p7l_s3 <= K7 * ttr_lo;
			p7h_s3 <= K7 * ttr_hi;
			p8l_s3 <= K8 * trr_lo;
			p8h_s3 <= K8 * trr_hi;
			p9l_s3 <= K9 * ttrr_lo;
			p9h_s3 <= K9 * ttrr_hi;
			t_s3   <= t_s2;
			byp_s3 <= byp_s2;
			cat_s3 <= cat_s2;
		end
	end

	// stage 4: rejoin halves and align every term to 2^-(W+32)
	logic signed [ACC_W-1:0] tm2_s4, tm3_s4, tm4_s4, tm5_s4, tm6_s4;
	logic signed [ACC_W-1:0] tm7_s4, tm8_s4, tm9_s4;
	logic signed [TW-1:0]    t_s4;
	logic                    byp_s4;
	hiw_pkg::cat_t           cat_s4;

	always_ff @(posedge clk) begin
		if (rdy_s4 && vld_s3) begin
			tm2_s4 <= ACC_W'(p2_s3) <<< 24;
			tm3_s4 <= ACC_W'(p3_s3) <<< 24;
			tm4_s4 <= ((ACC_W'(p4h_s3) <<< SW) + ACC_W'(p4l_s3)) <<< 16;
			tm5_s4 <= ((ACC_W'(p5h_s3) <<< SW) + ACC_W'(p5l_s3)) <<< 16;
			tm6_s4 <= ((ACC_W'(p6h_s3) <<< SW) + ACC_W'(p6l_s3)) <<< 16;
			tm7_s4 <= ((ACC_W'(p7h_s3) <<< SW) + ACC_W'(p7l_s3)) <<< 8;
			tm8_s4 <= ((ACC_W'(p8h_s3) <<< SW) + ACC_W'(p8l_s3)) <<< 8;
			tm9_s4 <= (ACC_W'(p9h_s3) <<< SW) + ACC_W'(p9l_s3);
			t_s4   <= t_s3;
			byp_s4 <= byp_s3;
			cat_s4 <= cat_s3;
		end
	end

	// stage 5: partial sums of three terms
	logic signed [ACC_W-1:0] g0_s5, g1_s5, g2_s5;
	logic signed [TW-1:0]    t_s5;
	logic                    byp_s5;
	hiw_pkg::cat_t           cat_s5;

	always_ff @(posedge clk) begin
		if (rdy_s5 && vld_s4) begin
			g0_s5  <= T1 + tm2_s4 + tm3_s4;
			g1_s5  <= tm4_s4 + tm5_s4 + tm6_s4;
			g2_s5  <= tm7_s4 + tm8_s4 + tm9_s4;
			t_s5   <= t_s4;
			byp_s5 <= byp_s4;
			cat_s5 <= cat_s4;
		end
	end

	// stage 6: full sum
	logic signed [ACC_W-1:0] sum_s6;
	logic signed [TW-1:0]    t_s6;
	logic                    byp_s6;
	hiw_pkg::cat_t           cat_s6;

	always_ff @(posedge clk) begin
		if (rdy_s6 && vld_s5) begin
			sum_s6 <= g0_s5 + g1_s5 + g2_s5;
			t_s6   <= t_s5;
			byp_s6 <= byp_s5;
			cat_s6 <= cat_s5;
		end
	end

	// stage 7: floor to 1/256, saturate, bypass select
	logic signed [Y_W-1:0] y_flr;
	logic signed [HW-1:0]  hi_sel;

	assign y_flr = $signed(sum_s6[ACC_W-1:FLR_SH]);

	always_comb begin
		if (byp_s6)             hi_sel = HW'(t_s6);
		else if (y_flr > Y_MAX) hi_sel = HI_MAX;
		else if (y_flr < Y_MIN) hi_sel = HI_MIN;
		else                    hi_sel = y_flr[HW-1:0];
	end

	logic signed [HW-1:0] hi_s7;
	hiw_pkg::cat_t        cat_s7;

	always_ff @(posedge clk) begin
		if (rdy_s7 && vld_s6) begin
			hi_s7  <= hi_sel;
			cat_s7 <= cat_s6;
		end
	end

	// output register: warning level
	hiw_pkg::warn_t warn_sel;

	always_comb begin
		if (hi_s7 > HW'(danger_q))       warn_sel = hiw_pkg::WARN_DANGER;
		else if (hi_s7 > HW'(extreme_q)) warn_sel = hiw_pkg::WARN_EXTREME;
		else if (hi_s7 > HW'(caution_q)) warn_sel = hiw_pkg::WARN_CAUTION;
		else                             warn_sel = hiw_pkg::WARN_NONE;
	end

	hiw_pkg::report_t out_q;

	always_ff @(posedge clk) begin
		if (rdy_o && vld_s7) begin
			out_q.heat_index    <= hi_s7;
			out_q.warning_level <= warn_sel;
			out_q.temp_category <= cat_s7;
		end
	end

	assign report.valid   = out_vld_q;
	assign report.payload = out_q;

`ifndef SYNTH
	a_no_refuse_with_bubble: assert property (@(posedge clk) disable iff (!arst_n)
		!reading.ready |-> (vld_s1 && vld_s2 && vld_s3 && vld_s4 && vld_s5 && vld_s6
			&& vld_s7 && out_vld_q))
		else $error("input refused while the pipe has an empty stage");

	a_danger_above_level: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && out_q.warning_level == hiw_pkg::WARN_DANGER)
			|-> (out_q.heat_index > HW'(danger_q)))
		else $error("danger warning with heat index at or below danger level");

	a_none_below_caution: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && out_q.warning_level == hiw_pkg::WARN_NONE)
			|-> (out_q.heat_index <= HW'(caution_q)))
		else $error("no warning with heat index above caution level");
`endif

endmodule

>>> dv/hiw_report_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hiw_report_checker
// Watches the reading and report channels and the register write port of the
// heat index core. Every reading transfer is turned into a predicted report:
// the Celsius heat index polynomial with coefficients rounded to the core's
// fixed-point step, exact products and a floored sum, then the warning level
// and the temperature category. Each report transfer is checked field by
// field against the oldest prediction. The failure count goes to the top.
// ----------------------------------------------------------------------------
module hiw_report_checker #(
	parameter int COEF_FRAC_BITS = hiw_pkg::COEF_FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [hiw_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [hiw_pkg::CFG_W-1:0]     cfg_data,
	hiw_stream_if                         reading,
	hiw_stream_if                         report,
	output int                            checks_failed,
	output int                            reports_pending,
	output int                            reports_checked,
	output logic [3:0]                    warn_seen,
	output logic [4:0]                    cat_seen
);
	import hiw_pkg::*;

	logic signed [CFG_W-1:0] formula_thr;
	logic signed [CFG_W-1:0] caution_thr;
	logic signed [CFG_W-1:0] extreme_thr;
	logic signed [CFG_W-1:0] danger_thr;

	report_t expected_reports[$];

	// decimal coefficient as num/den, its sign and the powers of T and R
	function automatic void rothfusz_coef(input int k, output longint unsigned num,
			output longint unsigned den, output bit neg, output int tp, output int rp);
		case (k)
			0: begin num = 64'd878469475556; den = 64'd100000000000; neg = 1; tp = 0; rp = 0; end
			1: begin num = 64'd161139411; den = 64'd100000000; neg = 0; tp = 1; rp = 0; end
			2: begin num = 64'd233854883889; den = 64'd100000000000; neg = 0; tp = 0; rp = 1; end
			3: begin num = 64'd14611605; den = 64'd100000000; neg = 1; tp = 1; rp = 1; end
			4: begin num = 64'd12308094; den = 64'd1000000000; neg = 1; tp = 2; rp = 0; end
			5: begin num = 64'd164248277778; den = 64'd10000000000000; neg = 1; tp = 0; rp = 2; end
			6: begin num = 64'd2211732; den = 64'd1000000000; neg = 0; tp = 2; rp = 1; end
			7: begin num = 64'd72546; den = 64'd100000000; neg = 0; tp = 1; rp = 2; end
			default: begin num = 64'd3582; den = 64'd1000000000; neg = 1; tp = 2; rp = 2; end
		endcase
	endfunction

	function automatic logic signed [HI_W-1:0] heat_poly(input logic signed [TEMP_W-1:0] t,
			input logic [HUM_W-1:0] r);
		longint unsigned num;
		longint unsigned den;
		bit neg;
		int tp;
		int rp;
		int k;
		int j;
		logic [127:0] quo;
		logic signed [127:0] tt;
		logic signed [127:0] rr;
		logic signed [127:0] term;
		logic signed [127:0] acc;
		logic signed [127:0] floored;
		tt = t;
		rr = {113'd0, r};
		acc = '0;
		for (k = 0; k < 9; k++) begin
			rothfusz_coef(k, num, den, neg, tp, rp);
			// round half away from zero on the magnitude
			quo = (128'(num) << (COEF_FRAC_BITS + 1)) / 128'(den);
			term = $signed((quo >> 1) + (quo & 128'd1));
			if (neg)
				term = -term;
			for (j = 0; j < tp; j++)
				term = term * tt;
			for (j = 0; j < rp; j++)
				term = term * rr;
			term = term <<< (8 * (4 - tp - rp));
			acc = acc + term;
		end
		floored = acc >>> (COEF_FRAC_BITS + 24);
		if (floored > 128'sd8388607)
			return 24'sh7FFFFF;
		if (floored < -128'sd8388608)
			return 24'sh800000;
		return floored[HI_W-1:0];
	endfunction

	function automatic report_t predict_report(input reading_t rd);
		report_t rep;
		logic signed [HI_W-1:0] hi;
		if (rd.air_temp < formula_thr)
			hi = rd.air_temp;
		else
			hi = heat_poly(rd.air_temp, rd.rel_humidity);
		rep.heat_index = hi;
		if (hi > danger_thr)
			rep.warning_level = WARN_DANGER;
		else if (hi > extreme_thr)
			rep.warning_level = WARN_EXTREME;
		else if (hi > caution_thr)
			rep.warning_level = WARN_CAUTION;
		else
			rep.warning_level = WARN_NONE;
		if (rd.air_temp < 0)
			rep.temp_category = CAT_FREEZING;
		else if (rd.air_temp < COLD_MIN)
			rep.temp_category = CAT_COLD;
		else if (rd.air_temp < COOL_MIN)
			rep.temp_category = CAT_COOL;
		else if (rd.air_temp < WARM_MIN)
			rep.temp_category = CAT_WARM;
		else
			rep.temp_category = CAT_HOT;
		return rep;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		report_t want;
		report_t got;
		if (!arst_n) begin
			formula_thr = FORMULA_RST;
			caution_thr = CAUTION_RST;
			extreme_thr = EXTREME_RST;
			danger_thr = DANGER_RST;
			expected_reports.delete();
			checks_failed = 0;
			reports_pending = 0;
			reports_checked = 0;
			warn_seen = '0;
			cat_seen = '0;
		end else begin
			if (reading.valid && reading.ready)
				expected_reports.insert(expected_reports.size(),
					predict_report(reading.payload));
			if (report.valid && report.ready) begin
				got = report.payload;
				if (expected_reports.size() == 0) begin
					checks_failed++;
					$display("%0t: report transfer with none expected: actual hi=%0d warn=%0d cat=%0d",
						$time, $signed(got.heat_index), got.warning_level, got.temp_category);
				end else begin
					want = expected_reports.pop_front();
					reports_checked++;
					warn_seen[want.warning_level] = 1'b1;
					cat_seen[want.temp_category] = 1'b1;
					if (got.heat_index !== want.heat_index) begin
						checks_failed++;
						$display("%0t: heat_index mismatch: expected %0d, actual %0d",
							$time, $signed(want.heat_index), $signed(got.heat_index));
					end
					if (got.warning_level !== want.warning_level) begin
						checks_failed++;
						$display("%0t: warning_level mismatch: expected %0d, actual %0d",
							$time, want.warning_level, got.warning_level);
					end
					if (got.temp_category !== want.temp_category) begin
						checks_failed++;
						$display("%0t: temp_category mismatch: expected %0d, actual %0d",
							$time, want.temp_category, got.temp_category);
					end
				end
			end
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_FORMULA: formula_thr = cfg_data;
					REG_CAUTION: caution_thr = cfg_data;
					REG_EXTREME: extreme_thr = cfg_data;
					REG_DANGER:  danger_thr = cfg_data;
					default: ;
				endcase
			end
			reports_pending = expected_reports.size();
		end
	end

endmodule

>>> dv/tb_heat_index_warning_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_heat_index_warning_core
// Drives readings into the heat index core in random bursts while the report
// side stalls on its own pattern, and walks the level registers through
// default, extreme, misordered and random settings. A directed opening hits
// field extremes, the formula threshold, category edges and strict level
// edges; random readings are mostly 20 to 50 C or near the threshold. The
// checker beside the core predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_heat_index_warning_core;
	import hiw_pkg::*;

	localparam int PHASES       = 8;
	localparam int PER_PHASE    = 160;
	localparam int HOLD_CYCLES  = 60;
	localparam int IDLE_LIMIT   = 2000;
	localparam int TAIL_CYCLES  = 20;

	typedef enum int {
		RX_OPEN,
		RX_COIN,
		RX_SPARSE,
		RX_PERIODIC
	} rx_mode_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	hiw_stream_if #(.payload_t(reading_t)) reading_ch ();
	hiw_stream_if #(.payload_t(report_t))  report_ch ();

	int checks_failed;
	int reports_pending;
	int reports_checked;
	logic [3:0] warn_seen;
	logic [4:0] cat_seen;

	int readings_sent;
	int settings_used;
	int hold_requests;
	int holds_done;
	int idle_cycles;
	logic signed [CFG_W-1:0] cur_formula;

	heat_index_warning_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.reading  (reading_ch),
		.report   (report_ch)
	);

	hiw_report_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.reading        (reading_ch),
		.report         (report_ch),
		.checks_failed  (checks_failed),
		.reports_pending(reports_pending),
		.reports_checked(reports_checked),
		.warn_seen      (warn_seen),
		.cat_seen       (cat_seen)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// cycles with no transfer on either channel
	always @(posedge clk) begin
		if ((reading_ch.valid && reading_ch.ready) || (report_ch.valid && report_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout after %0d idle cycles", idle_cycles);
			$display("status: fail");
			$finish;
		end
	end

	// report side: random stall modes, plus a long hold-off on request
	initial begin : report_sink
		rx_mode_t mode;
		int window;
		int tick;
		mode = RX_OPEN;
		window = 0;
		tick = 0;
		holds_done = 0;
		report_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (holds_done != hold_requests) begin
				report_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(posedge clk);
				holds_done++;
			end else begin
				if (window == 0) begin
					mode = rx_mode_t'($urandom_range(0, 3));
					window = $urandom_range(16, 96);
				end
				window--;
				tick++;
				case (mode)
					RX_OPEN:   report_ch.ready <= 1'b1;
					RX_COIN:   report_ch.ready <= 1'($urandom_range(0, 1));
					RX_SPARSE: report_ch.ready <= ($urandom_range(0, 3) == 0);
					default:   report_ch.ready <= (tick % 3 != 0);
				endcase
			end
		end
	end

	task automatic send_reading(input reading_t item);
		reading_ch.valid <= 1'b1;
		reading_ch.payload <= item;
		do @(posedge clk); while (!reading_ch.ready);
		readings_sent++;
	endtask

	task automatic send_pair(input int t, input int h);
		reading_t item;
		item.air_temp = 16'(t);
		item.rel_humidity = 15'(h);
		send_reading(item);
	endtask

	function automatic reading_t random_reading();
		reading_t item;
		int pick;
		int t;
		pick = $urandom_range(0, 9);
		if (pick < 5) begin
			item.air_temp = 16'($urandom_range(5120, 12800));
		end else if (pick < 7) begin
			t = int'(cur_formula) + int'($urandom_range(0, 1024)) - 512;
			if (t > 32767)
				t = 32767;
			if (t < -32768)
				t = -32768;
			item.air_temp = 16'(t);
		end else begin
			item.air_temp = 16'($urandom);
		end
		if ($urandom_range(0, 4) == 0)
			item.rel_humidity = 15'($urandom);
		else
			item.rel_humidity = 15'($urandom_range(0, 25600));
		return item;
	endfunction

	task automatic send_random(input int count);
		int left;
		int burst;
		int gap;
		left = count;
		while (left > 0) begin
			burst = $urandom_range(1, 40);
			if (burst > left)
				burst = left;
			repeat (burst) send_reading(random_reading());
			left -= burst;
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				reading_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// stop offering and wait until every predicted report has come back
	task automatic drain();
		reading_ch.valid <= 1'b0;
		@(posedge clk);
		while (reports_pending != 0) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input int value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= 16'(value);
		@(posedge clk);
		if (idx == REG_FORMULA)
			cur_formula = 16'(value);
	endtask

	task automatic set_levels(input int formula, input int caution, input int extreme,
			input int danger);
		write_reg(REG_FORMULA, formula);
		write_reg(REG_CAUTION, caution);
		write_reg(REG_EXTREME, extreme);
		write_reg(REG_DANGER, danger);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	task automatic apply_setting(input int phase);
		int c;
		int e;
		case (phase)
			0: set_levels(6912, 7680, 8960, 10240);
			1: set_levels(-32768, -32768, 0, 32767);
			2: set_levels(32767, 32767, 32767, 32767);
			3: set_levels(5120, 10240, 8960, 7680);
			4: set_levels(int'($urandom), int'($urandom), int'($urandom), int'($urandom));
			5: begin
				c = $urandom_range(6400, 8960);
				e = c + $urandom_range(0, 1280);
				set_levels($urandom_range(4608, 8960), c, e, e + $urandom_range(0, 2560));
			end
			6: set_levels(0, 8000, 8000, 8000);
			default: set_levels(6912, 7680, 8960, 10240);
		endcase
	endtask

	initial begin : stimulus
		int phase;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_FORMULA;
		cfg_data <= '0;
		reading_ch.valid <= 1'b0;
		reading_ch.payload <= '0;
		readings_sent = 0;
		settings_used = 1;
		hold_requests = 0;
		cur_formula = FORMULA_RST;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset levels: field extremes, threshold edge, category edges
		send_pair(-32768, 0);
		send_pair(32767, 25600);
		send_pair(32767, 32767);
		send_pair(-32768, 32767);
		send_pair(0, 0);
		send_pair(-1, 12800);
		send_pair(6911, 25600);
		send_pair(6912, 25600);
		send_pair(2559, 0);
		send_pair(2560, 100);
		send_pair(5119, 20000);
		send_pair(5120, 5000);
		send_pair(7679, 25600);
		send_pair(7680, 25600);
		drain();

		// formula only at full scale, so heat index follows air temp at level edges
		set_levels(32767, 0, 2560, 5120);
		send_pair(0, 12800);
		send_pair(1, 12800);
		send_pair(2560, 12800);
		send_pair(2561, 12800);
		send_pair(5120, 12800);
		send_pair(5121, 12800);
		send_pair(32767, 0);

		for (phase = 0; phase < PHASES; phase++) begin
			drain();
			apply_setting(phase);
			if (phase == 2) begin
				// long report stall while readings keep coming
				hold_requests++;
				repeat (30) send_reading(random_reading());
			end
			send_random(PER_PHASE);
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("covered %0d readings, %0d reports checked, %0d level settings",
			readings_sent, reports_checked, settings_used);
		$display("warning levels seen %b, temperature categories seen %b", warn_seen, cat_seen);
		if (checks_failed == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
